// File: src/rpsd_pkg.sv
package rpsd_pkg;

    // Default capacity of one stream in bytes.
    localparam int MAX_STREAM_BYTES_DEF = 8192;

    // Fixed header layout.
    localparam int HEADER_BYTES  = 12;
    localparam int HDR_TYPE_IDX  = 0;
    localparam int HDR_LEN_LO    = 2;
    localparam int HDR_LEN_HI    = 3;
    localparam int HDR_OFF_LO    = 4;
    localparam int HDR_OFF_HI    = 5;
    localparam int HDR_LAST_IDX  = HEADER_BYTES - 1;

    // Field widths.
    localparam int BYTE_W        = 8;
    localparam int TYPE_W        = 4;
    localparam int STREAM_LEN_W  = 14;
    localparam int PAY_LEN_W     = 13;
    localparam int SEEN_W        = 4;

    // Reset value of the private interface type register.
    localparam logic [TYPE_W-1:0] PRIV_TYPE_RESET = 4'd4;

    // Depth of the queue between parser and output stage.
    localparam int QUEUE_DEPTH   = 2;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0]    payload_byte;
        logic [TYPE_W-1:0]    interface_type;
        logic [PAY_LEN_W-1:0] payload_length;
        logic                 last_in_packet;
    } item_t;

    // Write side of the queue.
    typedef struct packed {
        logic  push;
        item_t item;
    } queue_wr_t;

    // Status of the queue as seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

// File: src/rx_packet_stream_deframer_core.sv
// Channel  | Direction | Ports                        | Contents
// ---------+-----------+------------------------------+----------------------------------------
// s_       | in        | s_tvalid s_tready s_tdata    | tdata: [7:0] stream_byte,
//          |           | s_tuser                      |   [21:8] stream_length; tuser: start
// m_       | out       | m_tvalid m_tready m_tdata    | tdata: [7:0] payload_byte,
//          |           | m_tuser m_tlast              |   [20:8] payload_length; tuser: type
// cfg_     | in        | cfg_valid cfg_ready cfg_data | private interface type (4 bits)
//
// One stream byte is taken per cycle while the queue is not full; the parser handles each byte
// in the cycle of its transfer. An emitted payload byte passes through the queue and then the
// output register before its m_ transfer.
// A two-entry queue sits between the parser and the output register; s_tready drops only
// when that queue is full, so a stall on m_ reaches s_ after three held results (one in the
// output register and two in the queue).
// Reset is synchronous on aresetn low and clears the parser, queue and output valid.
// cfg_ready is always high; a write takes effect on the next cycle.
module rx_packet_stream_deframer_core #(
    parameter int MAX_STREAM_BYTES = rpsd_pkg::MAX_STREAM_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,  // stream_byte, stream_length, pad
    input  logic                              s_tuser,  // stream_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,  // payload_byte, payload_length, pad
    output logic [rpsd_pkg::TYPE_W-1:0]       m_tuser,  // interface_type
    output logic                              m_tlast,  // last_in_packet
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpsd_pkg::TYPE_W-1:0]       cfg_data
);

    rpsd_pkg::queue_wr_t    q_wr;
    rpsd_pkg::queue_stat_t  q_stat;
    rpsd_pkg::item_t        q_item;
    rpsd_pkg::item_t        out_item;
    logic                   q_pop;

    assign cfg_ready = 1'b1;

    // Parser: takes stream bytes and classifies them.
    rpsd_front #(
        .MAX_STREAM_BYTES(MAX_STREAM_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata[7:0]),
        .in_start  (s_tuser),
        .in_length (s_tdata[21:8]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_wr      (q_wr)
    );

    // Queue between parser and output stage.
    rpsd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .pop     (q_pop),
        .rd_item (q_item),
        .stat    (q_stat)
    );

    // Output register stage.
    rpsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // Pack the result fields onto the master side.
    assign m_tdata = {3'b000, out_item.payload_length, out_item.payload_byte};
    assign m_tuser = out_item.interface_type;
    assign m_tlast = out_item.last_in_packet;

endmodule

// File: src/rpsd_front.sv
module rpsd_front #(
    parameter int MAX_STREAM_BYTES = rpsd_pkg::MAX_STREAM_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rpsd_pkg::BYTE_W-1:0]         in_byte,
    input  logic                                in_start,
    input  logic [rpsd_pkg::STREAM_LEN_W-1:0]   in_length,
    input  logic                                cfg_we,
    input  logic [rpsd_pkg::TYPE_W-1:0]         cfg_data,
    input  rpsd_pkg::queue_stat_t               q_stat,
    output rpsd_pkg::queue_wr_t                 q_wr
);

    localparam int LEN_W = $clog2(MAX_STREAM_BYTES + 1);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [LEN_W-1:0]                pos_reg, pos_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic [LEN_W-1:0]                left_reg, left_next;
    logic [rpsd_pkg::SEEN_W-1:0]     seen_reg, seen_next;
    logic [rpsd_pkg::TYPE_W-1:0]     priv_reg, priv_next;
    logic [rpsd_pkg::TYPE_W-1:0]     type_reg, type_next;
    logic [rpsd_pkg::PAY_LEN_W-1:0]  plen_reg, plen_next;
    logic [rpsd_pkg::TYPE_W-1:0]     hdr0_reg, hdr0_next;
    logic [rpsd_pkg::BYTE_W-1:0]     hdr2_reg, hdr2_next;
    logic [rpsd_pkg::BYTE_W-1:0]     hdr3_reg, hdr3_next;
    logic [rpsd_pkg::BYTE_W-1:0]     hdr4_reg, hdr4_next;
    logic [rpsd_pkg::BYTE_W-1:0]     hdr5_reg, hdr5_next;

    logic                            accept;
    logic [LEN_W-1:0]                len_eff, pos_eff, left_eff, remain, remain_after, left_dec;
    logic [rpsd_pkg::SEEN_W-1:0]     seen_eff;
    phase_t                          phase_eff, phase_work;
    logic                            active;
    logic [15:0]                     hdr_len, hdr_off;
    logic                            bad_hdr;
    logic                            last;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    assign hdr_len = {hdr3_reg, hdr2_reg};
    assign hdr_off = {hdr5_reg, hdr4_reg};

    // A stream start restarts parsing before the byte itself is handled.
    always_comb begin
        if (in_start) begin
            if (32'(in_length) > 32'(MAX_STREAM_BYTES)) begin
                len_eff = LEN_W'(MAX_STREAM_BYTES);
            end else begin
                len_eff = LEN_W'(in_length);
            end
            pos_eff   = '0;
            phase_eff = PH_HEADER;
            seen_eff  = '0;
            left_eff  = '0;
        end else begin
            len_eff   = len_reg;
            pos_eff   = pos_reg;
            phase_eff = phase_reg;
            seen_eff  = seen_reg;
            left_eff  = left_reg;
        end
    end

    assign active       = pos_eff < len_eff;
    assign remain       = len_eff - pos_eff;
    assign remain_after = remain - LEN_W'(1);
    assign left_dec     = left_eff - LEN_W'(1);
    assign last         = (left_dec == '0);

    // A header with fewer bytes left than a full header ends the stream.
    always_comb begin
        phase_work = phase_eff;
        if (phase_eff == PH_HEADER && seen_eff == '0
                && remain < LEN_W'(rpsd_pkg::HEADER_BYTES)) begin
            phase_work = PH_DONE;
        end
    end

    assign bad_hdr = (hdr_len == '0) || (hdr_off != 16'(rpsd_pkg::HEADER_BYTES))
                     || (32'(hdr_len) > 32'(remain_after));

    // Next-state logic of the parser.
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        seen_next  = seen_reg;
        priv_next  = priv_reg;
        type_next  = type_reg;
        plen_next  = plen_reg;
        hdr0_next  = hdr0_reg;
        hdr2_next  = hdr2_reg;
        hdr3_next  = hdr3_reg;
        hdr4_next  = hdr4_reg;
        hdr5_next  = hdr5_reg;
        q_wr.push  = 1'b0;
        q_wr.item.payload_byte   = in_byte;
        q_wr.item.interface_type = type_reg;
        q_wr.item.payload_length = plen_reg;
        q_wr.item.last_in_packet = last;

        if (cfg_we) begin
            priv_next = cfg_data;
        end

        if (accept) begin
            phase_next = phase_eff;
            pos_next   = pos_eff;
            len_next   = len_eff;
            left_next  = left_eff;
            seen_next  = seen_eff;
            if (active) begin
                phase_next = phase_work;
                pos_next   = pos_eff + LEN_W'(1);
                case (phase_work)
                    PH_HEADER: begin
                        // Keep only the header bytes that are judged later.
                        case (32'(seen_eff))
                            rpsd_pkg::HDR_TYPE_IDX: hdr0_next = in_byte[rpsd_pkg::TYPE_W-1:0];
                            rpsd_pkg::HDR_LEN_LO:   hdr2_next = in_byte;
                            rpsd_pkg::HDR_LEN_HI:   hdr3_next = in_byte;
                            rpsd_pkg::HDR_OFF_LO:   hdr4_next = in_byte;
                            rpsd_pkg::HDR_OFF_HI:   hdr5_next = in_byte;
                            default: ;
                        endcase
                        if (32'(seen_eff) == rpsd_pkg::HDR_LAST_IDX) begin
                            seen_next = '0;
                            if (bad_hdr) begin
                                phase_next = PH_DONE;
                            end else begin
                                phase_next = PH_PAYLOAD;
                                type_next  = hdr0_reg;
                                plen_next  = hdr_len[rpsd_pkg::PAY_LEN_W-1:0];
                                left_next  = LEN_W'(hdr_len);
                            end
                        end else begin
                            seen_next = seen_eff + rpsd_pkg::SEEN_W'(1);
                        end
                    end
                    PH_PAYLOAD: begin
                        left_next = left_dec;
                        if (last) begin
                            phase_next = PH_HEADER;
                        end
                        q_wr.push = (type_reg != priv_reg);
                    end
                    default: ;
                endcase
            end
        end
    end

    // Parser state and the configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            len_reg   <= '0;
            seen_reg  <= '0;
            priv_reg  <= rpsd_pkg::PRIV_TYPE_RESET;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            priv_reg  <= priv_next;
        end
        left_reg <= left_next;
        type_reg <= type_next;
        plen_reg <= plen_next;
        hdr0_reg <= hdr0_next;
        hdr2_reg <= hdr2_next;
        hdr3_reg <= hdr3_next;
        hdr4_reg <= hdr4_next;
        hdr5_reg <= hdr5_next;
    end

    // A payload phase always has bytes left to consume.
    a_payload_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> left_reg != '0)
        else $error("payload phase with no bytes left");

    // The position never runs past the stream length.
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= len_reg)
        else $error("stream position past stream length");

endmodule

// File: src/rpsd_queue.sv
module rpsd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rpsd_pkg::queue_wr_t    wr,
    input  logic                   pop,
    output rpsd_pkg::item_t        rd_item,
    output rpsd_pkg::queue_stat_t  stat
);

    localparam int PTR_W = (rpsd_pkg::QUEUE_DEPTH > 1) ? $clog2(rpsd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(rpsd_pkg::QUEUE_DEPTH + 1);

    rpsd_pkg::item_t   mem_reg [rpsd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CNT_W'(rpsd_pkg::QUEUE_DEPTH));
    assign do_push    = wr.push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_item    = mem_reg[rptr_reg];

    // Pointer and fill count updates with wrap at the queue depth.
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (32'(wptr_reg) == rpsd_pkg::QUEUE_DEPTH - 1) ? '0
                        : wptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rptr_next = (32'(rptr_reg) == rpsd_pkg::QUEUE_DEPTH - 1) ? '0
                        : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wptr_reg] <= wr.item;
        end
    end

    // The parser never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.push |-> !stat.full)
        else $error("push into full queue");

    // The output stage never pops an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("pop from empty queue");

    // The fill count stays within the depth.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(rpsd_pkg::QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

// File: src/rpsd_back.sv
module rpsd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rpsd_pkg::queue_stat_t  q_stat,
    input  rpsd_pkg::item_t        q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rpsd_pkg::item_t        out_item
);

    logic             valid_reg, valid_next;
    rpsd_pkg::item_t  item_reg, item_next;

    // Load a new item when the output register is free or being drained.
    assign q_pop = !q_stat.empty && (!valid_reg || out_ready);

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (q_pop) begin
            valid_next = 1'b1;
            item_next  = q_item;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
